// ===== src/lhrv_pkg.sv =====
package lhrv_pkg;

  // Field widths of the channels and the configuration register
  localparam int unsigned CmdW      = 2;
  localparam int unsigned PixW      = 8;
  localparam int unsigned BinIdxW   = 8;
  localparam int unsigned BinCntW   = 25;
  localparam int unsigned MeanW     = 22;
  localparam int unsigned RowsW     = 13;
  localparam int unsigned RowWidthW = 13;

  // Sizing of the statistics
  localparam int unsigned MaxRowWidth = 4096;
  localparam int unsigned MaxRows     = 4096;
  localparam int unsigned BinCount    = 256;
  localparam int unsigned FracBits    = 8;
  localparam int unsigned PosW        = $clog2(MaxRowWidth);
  localparam int unsigned SumW        = 21;
  localparam int unsigned SqW         = 29;
  localparam int unsigned AccW        = 34;
  localparam int unsigned ProdW       = SqW + SumW;
  localparam int unsigned NumW        = 41;
  localparam int unsigned DvdW        = NumW + FracBits;
  localparam int unsigned DvsW        = 25;

  localparam logic [BinCntW-1:0]   BinLimit      = BinCntW'(16777216);
  localparam logic [RowWidthW-1:0] RowWidthReset = RowWidthW'(1920);

  typedef enum logic [CmdW-1:0] {
    CMD_PIXEL = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Histogram memory control
  typedef struct packed {
    logic               clear;
    logic               rd_en;
    logic [BinIdxW-1:0] rd_addr;
    logic               wr_en;
    logic [BinIdxW-1:0] wr_addr;
    logic [BinCntW-1:0] wr_data;
  } hist_req_t;

  // Divider control and status
  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DvdW-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== src/lhrv_in_if.sv =====
interface lhrv_in_if import lhrv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CmdW-1:0]    command;
  logic [PixW-1:0]    pixel_value;
  logic               last_of_frame;
  logic [BinIdxW-1:0] bin_index;

  modport source (
    output valid, command, pixel_value, last_of_frame, bin_index,
    input  ready
  );
  modport sink (
    input  valid, command, pixel_value, last_of_frame, bin_index,
    output ready
  );
endinterface

// ===== src/lhrv_out_if.sv =====
interface lhrv_out_if import lhrv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BinCntW-1:0] bin_count;
  logic [MeanW-1:0]   mean_variance_q8;
  logic               variance_valid;
  logic [RowsW-1:0]   rows_counted;

  modport source (
    output valid, bin_count, mean_variance_q8, variance_valid, rows_counted,
    input  ready
  );
  modport sink (
    input  valid, bin_count, mean_variance_q8, variance_valid, rows_counted,
    output ready
  );
endinterface

// ===== src/lhrv_hist.sv =====
module lhrv_hist import lhrv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hist_req_t          req_i,
  output logic [BinCntW-1:0] rd_data_o
);

  logic [BinCntW-1:0] mem_q [BinCount];
  logic [BinCount-1:0] vld_q;
  logic [BinCntW-1:0] rd_data_q;
  logic               rd_vld_q;

  // Track written bins; clear drops every bin at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  // Bin storage, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  // An unwritten bin reads as zero
  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== src/lhrv_div.sv =====
module lhrv_div import lhrv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(DvdW);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DvdW-1:0] dvd_q;
  logic [DvsW-1:0] rem_q;
  logic [DvsW-1:0] dvs_q;

  logic [DvsW:0]   trial;
  logic [DvsW:0]   diff;
  logic            ge;

  // One restoring step: shift in the next dividend bit, try the subtract
  always_comb begin
    trial = {rem_q, dvd_q[DvdW-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = trial >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        dvd_q  <= req_i.dividend;
        rem_q  <= '0;
        dvs_q  <= req_i.divisor;
      end else if (busy_q) begin
        rem_q <= ge ? diff[DvsW-1:0] : trial[DvsW-1:0];
        dvd_q <= {dvd_q[DvdW-2:0], ge};
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(DvdW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

// ===== src/luma_histogram_row_variance_core.sv =====
// Channel   Direction  Payload                                                    Handshake
// item_i    in         command, pixel_value, last_of_frame, bin_index             valid/ready
// result_o  out        bin_count, mean_variance_q8, variance_valid, rows_counted   valid/ready
// cfg       in         cfg_wdata_i (row_width)                                     cfg_we_i
//
// One transaction at a time; ready drops from accept until the result is loaded.
// Read, clear and no-op go straight to the response state; a pixel inside a row
// passes through the histogram and sums states. At a row or frame end the shared multiplier
// runs three more products and the radix-2 divider runs 49 steps per division.
// rst_ni clears the control state and every histogram bin at once, with no sweep.
// A full output register stalls the sequencer before it loads the next result.
module luma_histogram_row_variance_core import lhrv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  lhrv_in_if.sink              item_i,
  lhrv_out_if.source           result_o,
  input  logic                 cfg_we_i,
  input  logic [RowWidthW-1:0] cfg_wdata_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_HIST,
    S_SUMS,
    S_MUL_NSQ,
    S_MUL_SS,
    S_MUL_NN,
    S_DIV_ROW_GO,
    S_DIV_ROW,
    S_DIV_FRAME_GO,
    S_DIV_FRAME,
    S_RESP
  } state_e;

  state_e               state_q;
  cmd_e                 cmd_q;
  logic [PixW-1:0]      pix_q;
  logic                 last_q;
  logic [PosW-1:0]      pos_q;
  logic [SumW-1:0]      row_sum_q;
  logic [SqW-1:0]       row_sq_q;
  logic [AccW-1:0]      acc_q;
  logic [RowsW-1:0]     row_cnt_q;
  logic [RowWidthW-1:0] row_width_q;
  logic [NumW-1:0]      a_q;
  logic [NumW-1:0]      num_q;
  logic [ProdW-1:0]     prod_q;
  logic [MeanW-1:0]     res_mean_q;
  logic                 res_vvalid_q;
  logic [RowsW-1:0]     res_rows_q;
  logic                 out_valid_q;
  logic [BinCntW-1:0]   out_bin_q;
  logic [MeanW-1:0]     out_mean_q;
  logic                 out_vvalid_q;
  logic [RowsW-1:0]     out_rows_q;

  hist_req_t            hist_req;
  logic [BinCntW-1:0]   hist_rd;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  logic                 accept;
  cmd_e                 in_cmd;
  logic [RowWidthW-1:0] w_eff;
  logic [RowsW-1:0]     n_row;
  logic                 row_end;
  logic [SqW-1:0]       mul_a;
  logic [SumW-1:0]      mul_b;
  logic [AccW:0]        acc_sum;
  logic                 row_counts;
  logic                 slot_free;

  assign accept = item_i.valid && item_i.ready;
  assign in_cmd = cmd_e'(item_i.command);

  assign item_i.ready = (state_q == S_IDLE);

  // Clamp the row width and detect the end of a row
  always_comb begin
    if (row_width_q == '0) begin
      w_eff = RowWidthW'(1);
    end else if (row_width_q > RowWidthW'(MaxRowWidth)) begin
      w_eff = RowWidthW'(MaxRowWidth);
    end else begin
      w_eff = row_width_q;
    end
    n_row   = RowsW'(pos_q) + RowsW'(1);
    row_end = (n_row >= w_eff) || last_q;
  end

  // Select the operands of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_HIST: begin
        mul_a = SqW'(pix_q);
        mul_b = SumW'(pix_q);
      end
      S_MUL_NSQ: begin
        mul_a = row_sq_q;
        mul_b = SumW'(n_row);
      end
      S_MUL_SS: begin
        mul_a = SqW'(row_sum_q);
        mul_b = row_sum_q;
      end
      S_MUL_NN: begin
        mul_a = SqW'(n_row);
        mul_b = SumW'(n_row);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Histogram access: read on accept, write back the bin incremented up to BinLimit
  always_comb begin
    hist_req.clear   = accept && (in_cmd == CMD_CLEAR);
    hist_req.rd_en   = accept && ((in_cmd == CMD_PIXEL) || (in_cmd == CMD_READ));
    hist_req.rd_addr = (in_cmd == CMD_PIXEL) ? item_i.pixel_value : item_i.bin_index;
    hist_req.wr_en   = (state_q == S_HIST);
    hist_req.wr_addr = pix_q;
    hist_req.wr_data = (hist_rd < BinLimit) ? hist_rd + BinCntW'(1) : hist_rd;
  end

  lhrv_hist u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (hist_req),
    .rd_data_o (hist_rd)
  );

  // Divider requests: row variance, then frame mean
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {num_q, {FracBits{1'b0}}};
    div_req.divisor  = prod_q[DvsW-1:0];
    if (state_q == S_DIV_ROW_GO) begin
      div_req.start = 1'b1;
    end else if (state_q == S_DIV_FRAME_GO) begin
      div_req.start    = (row_cnt_q != '0);
      div_req.dividend = DvdW'(acc_q);
      div_req.divisor  = DvsW'(row_cnt_q);
    end
  end

  lhrv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    acc_sum    = {1'b0, acc_q} + (AccW + 1)'(div_rsp.quotient[DvsW-1:0]);
    row_counts = row_cnt_q < RowsW'(MaxRows);
    slot_free  = !out_valid_q || result_o.ready;
  end

  // Sequencer, statistics and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= CMD_NONE;
      pix_q        <= '0;
      last_q       <= 1'b0;
      pos_q        <= '0;
      row_sum_q    <= '0;
      row_sq_q     <= '0;
      acc_q        <= '0;
      row_cnt_q    <= '0;
      row_width_q  <= RowWidthReset;
      a_q          <= '0;
      num_q        <= '0;
      res_mean_q   <= '0;
      res_vvalid_q <= 1'b0;
      res_rows_q   <= '0;
      out_valid_q  <= 1'b0;
      out_bin_q    <= '0;
      out_mean_q   <= '0;
      out_vvalid_q <= 1'b0;
      out_rows_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        row_width_q <= cfg_wdata_i;
      end
      if (out_valid_q && result_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q        <= in_cmd;
            pix_q        <= item_i.pixel_value;
            last_q       <= item_i.last_of_frame;
            res_mean_q   <= '0;
            res_vvalid_q <= 1'b0;
            res_rows_q   <= row_cnt_q;
            unique case (in_cmd)
              CMD_PIXEL: begin
                state_q <= S_HIST;
              end
              CMD_CLEAR: begin
                pos_q      <= '0;
                row_sum_q  <= '0;
                row_sq_q   <= '0;
                acc_q      <= '0;
                row_cnt_q  <= '0;
                res_rows_q <= '0;
                state_q    <= S_RESP;
              end
              default: begin
                state_q <= S_RESP;
              end
            endcase
          end
        end
        S_HIST: begin
          state_q <= S_SUMS;
        end
        S_SUMS: begin
          row_sum_q <= row_sum_q + SumW'(pix_q);
          row_sq_q  <= row_sq_q + SqW'(prod_q[2*PixW-1:0]);
          if (row_end) begin
            state_q <= S_MUL_NSQ;
          end else begin
            pos_q   <= pos_q + PosW'(1);
            state_q <= S_RESP;
          end
        end
        S_MUL_NSQ: begin
          state_q <= S_MUL_SS;
        end
        S_MUL_SS: begin
          a_q     <= prod_q[NumW-1:0];
          state_q <= S_MUL_NN;
        end
        S_MUL_NN: begin
          num_q   <= (a_q > prod_q[NumW-1:0]) ? a_q - prod_q[NumW-1:0] : '0;
          state_q <= S_DIV_ROW_GO;
        end
        S_DIV_ROW_GO: begin
          state_q <= S_DIV_ROW;
        end
        S_DIV_ROW: begin
          if (div_rsp.done) begin
            pos_q     <= '0;
            row_sum_q <= '0;
            row_sq_q  <= '0;
            if (row_counts) begin
              acc_q      <= acc_sum[AccW] ? {AccW{1'b1}} : acc_sum[AccW-1:0];
              row_cnt_q  <= row_cnt_q + RowsW'(1);
              res_rows_q <= row_cnt_q + RowsW'(1);
            end else begin
              res_rows_q <= row_cnt_q;
            end
            state_q <= last_q ? S_DIV_FRAME_GO : S_RESP;
          end
        end
        S_DIV_FRAME_GO: begin
          res_rows_q <= row_cnt_q;
          if (row_cnt_q == '0) begin
            res_mean_q   <= '0;
            res_vvalid_q <= 1'b1;
            acc_q        <= '0;
            state_q      <= S_RESP;
          end else begin
            state_q <= S_DIV_FRAME;
          end
        end
        S_DIV_FRAME: begin
          if (div_rsp.done) begin
            res_mean_q   <= (|div_rsp.quotient[DvdW-1:MeanW]) ? {MeanW{1'b1}}
                                                              : div_rsp.quotient[MeanW-1:0];
            res_vvalid_q <= 1'b1;
            acc_q        <= '0;
            row_cnt_q    <= '0;
            state_q      <= S_RESP;
          end
        end
        S_RESP: begin
          if (slot_free) begin
            out_valid_q  <= 1'b1;
            out_bin_q    <= (cmd_q == CMD_READ) ? hist_rd : '0;
            out_mean_q   <= res_mean_q;
            out_vvalid_q <= res_vvalid_q;
            out_rows_q   <= res_rows_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.bin_count        = out_bin_q;
  assign result_o.mean_variance_q8 = out_mean_q;
  assign result_o.variance_valid   = out_vvalid_q;
  assign result_o.rows_counted     = out_rows_q;

endmodule

// ===== src/lhrv_checker.sv =====
module lhrv_checker import lhrv_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [BinCntW-1:0] bin_count_i,
  input logic [MeanW-1:0]   mean_i,
  input logic               vvalid_i,
  input logic [RowsW-1:0]   rows_i
);

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(bin_count_i)
      && $stable(mean_i) && $stable(vvalid_i) && $stable(rows_i))
    else $error("stalled result changed");

  // Drop ready after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready high right after accept");

  // A frame result carries a row count and no bin count
  a_frame_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && vvalid_i |-> rows_i != '0 && bin_count_i == '0)
    else $error("frame result without rows or with a bin count");

  // Mean is zero outside a frame result
  a_mean_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !vvalid_i |-> mean_i == '0)
    else $error("mean set on a non-frame result");

endmodule

bind luma_histogram_row_variance_core lhrv_checker u_lhrv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .bin_count_i (result_o.bin_count),
  .mean_i      (result_o.mean_variance_q8),
  .vvalid_i    (result_o.variance_valid),
  .rows_i      (result_o.rows_counted)
);
